>>> hdl/wqm_pkg.sv
package wqm_pkg;

  localparam int NUM_WAITERS = 32;
  localparam int SLOT_W      = $clog2(NUM_WAITERS);
  // link entries carry one extra bit so they can encode the null slot
  localparam int LINK_W      = SLOT_W + 1;
  localparam int ID_W        = 5;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [ID_W-1:0]   id_t;

  localparam link_t NULL_SLOT  = LINK_W'(NUM_WAITERS);
  localparam slot_t LAST_COUNT = SLOT_W'(NUM_WAITERS - 1);

  typedef enum logic [1:0] {
    KIND_ADD       = 2'd0,
    KIND_DELETE    = 2'd1,
    KIND_WAKE_ONE  = 2'd2,
    KIND_WAKE_ALL  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_LINK,
    ST_ADD_TERM,
    ST_DELETE,
    ST_WAKE_ONE,
    ST_WAKE_ALL
  } state_t;

  function automatic logic link_ok(link_t l);
    return l < NULL_SLOT;
  endfunction

  function automatic link_t link_norm(link_t l);
    return link_ok(l) ? l : NULL_SLOT;
  endfunction

endpackage

>>> hdl/wqm_ram.sv
module wqm_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/wait_queue_manager.sv
// FIFO wait queue of waiter slots, kept as a doubly linked list in two link
// memories (next, prev) plus a notify memory, all with registered reads.
// An item is taken when start is high and busy is low; its results come out
// on the result ports, one per cycle, each marked by result_strobe for a
// single cycle, and cannot be held off. Each result appears the cycle after
// the state that produces it. For add, delete and wake-one that state is the
// item's last, so busy is already low when the result shows. A wake-all
// reports one waiter per cycle while it walks the list, and only its final
// result arrives with busy low. An add passes through a tail link write, then
// the new entry's terminating link write, as the two share the single
// next-memory write port; a duplicate or out-of-range add ends in the link
// step without writing. A wake-all walks the list at the pace of the
// registered read of the next-link memory, and on an empty queue it reports
// one empty result. Reset takes effect at once; no clearing pass is needed.
module wait_queue_manager (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [1:0]             kind,
  input  logic [wqm_pkg::ID_W-1:0] waiter_id,
  input  logic                   notify,
  output logic                   busy,
  output logic                   result_strobe,
  output logic                   woken_valid,
  output logic [wqm_pkg::ID_W-1:0] woken_id,
  output logic                   woken_notify,
  output logic                   last,
  output logic                   queue_empty,
  output logic                   error
);

  wqm_pkg::state_t state, state_next;

  wqm_pkg::kind_t op_kind;
  wqm_pkg::id_t   op_id;
  logic           op_notify;
  wqm_pkg::slot_t op_slot;
  logic           op_ok;

  wqm_pkg::link_t head, head_next;
  wqm_pkg::link_t tail, tail_next;
  wqm_pkg::link_t cur, cur_next;
  wqm_pkg::slot_t count, count_next;
  logic [wqm_pkg::NUM_WAITERS-1:0] queued, queued_next;

  // memory ports
  wqm_pkg::slot_t rd_addr;
  wqm_pkg::link_t next_rd, prev_rd;
  logic           ntf_rd;
  logic           next_we, prev_we, ntf_we;
  wqm_pkg::slot_t next_waddr, prev_waddr, ntf_waddr;
  wqm_pkg::link_t next_wdata, prev_wdata;
  logic           ntf_wdata;

  logic           emit, emit_valid, emit_notify, emit_last, emit_error;
  wqm_pkg::id_t   emit_id;
  logic           wa_more;
  wqm_pkg::kind_t in_kind;

  assign in_kind = wqm_pkg::kind_t'(kind);
  assign busy    = (state != wqm_pkg::ST_IDLE);
  assign op_slot = wqm_pkg::SLOT_W'(op_id);
  assign op_ok   = 32'(op_id) < wqm_pkg::NUM_WAITERS;

  // wake-all keeps walking while the current waiter has a successor, up to NUM_WAITERS waiters in all
  assign wa_more = wqm_pkg::link_ok(cur) && wqm_pkg::link_ok(next_rd) &&
                   (count != wqm_pkg::LAST_COUNT);

  wqm_ram #(.WIDTH(wqm_pkg::LINK_W), .DEPTH(wqm_pkg::NUM_WAITERS)) u_next_mem (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (rd_addr),
    .rdata (next_rd)
  );

  wqm_ram #(.WIDTH(wqm_pkg::LINK_W), .DEPTH(wqm_pkg::NUM_WAITERS)) u_prev_mem (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (rd_addr),
    .rdata (prev_rd)
  );

  wqm_ram #(.WIDTH(1), .DEPTH(wqm_pkg::NUM_WAITERS)) u_ntf_mem (
    .clk   (clk),
    .we    (ntf_we),
    .waddr (ntf_waddr),
    .wdata (ntf_wdata),
    .raddr (rd_addr),
    .rdata (ntf_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wqm_pkg::ST_IDLE: begin
        if (start) begin
          unique case (in_kind)
            wqm_pkg::KIND_ADD:      state_next = wqm_pkg::ST_ADD_LINK;
            wqm_pkg::KIND_DELETE:   state_next = wqm_pkg::ST_DELETE;
            wqm_pkg::KIND_WAKE_ONE: state_next = wqm_pkg::ST_WAKE_ONE;
            wqm_pkg::KIND_WAKE_ALL: state_next = wqm_pkg::ST_WAKE_ALL;
            default:                state_next = wqm_pkg::ST_IDLE;
          endcase
        end
      end
      wqm_pkg::ST_ADD_LINK: begin
        state_next = (op_ok && !queued[op_slot]) ? wqm_pkg::ST_ADD_TERM
                                                 : wqm_pkg::ST_IDLE;
      end
      wqm_pkg::ST_ADD_TERM: state_next = wqm_pkg::ST_IDLE;
      wqm_pkg::ST_DELETE:   state_next = wqm_pkg::ST_IDLE;
      wqm_pkg::ST_WAKE_ONE: state_next = wqm_pkg::ST_IDLE;
      wqm_pkg::ST_WAKE_ALL: begin
        state_next = wa_more ? wqm_pkg::ST_WAKE_ALL : wqm_pkg::ST_IDLE;
      end
      default: state_next = wqm_pkg::ST_IDLE;
    endcase
  end

  // memory controls, list pointers and results
  always_comb begin
    next_we     = 1'b0;
    next_waddr  = op_slot;
    next_wdata  = wqm_pkg::NULL_SLOT;
    prev_we     = 1'b0;
    prev_waddr  = op_slot;
    prev_wdata  = wqm_pkg::NULL_SLOT;
    ntf_we      = 1'b0;
    ntf_waddr   = op_slot;
    ntf_wdata   = op_notify;
    head_next   = head;
    tail_next   = tail;
    cur_next    = cur;
    count_next  = count;
    queued_next = queued;
    emit        = 1'b0;
    emit_valid  = 1'b0;
    emit_id     = '0;
    emit_notify = 1'b0;
    emit_last   = 1'b1;
    emit_error  = 1'b0;
    // wake kinds look at the head entry, add and delete at the named slot
    if (in_kind == wqm_pkg::KIND_WAKE_ONE || in_kind == wqm_pkg::KIND_WAKE_ALL) begin
      rd_addr = head[wqm_pkg::SLOT_W-1:0];
    end else begin
      rd_addr = wqm_pkg::SLOT_W'(waiter_id);
    end

    unique case (state)
      wqm_pkg::ST_IDLE: begin
        if (start && in_kind == wqm_pkg::KIND_WAKE_ALL) begin
          cur_next   = head;
          count_next = '0;
          head_next  = wqm_pkg::NULL_SLOT;
          tail_next  = wqm_pkg::NULL_SLOT;
        end
      end
      wqm_pkg::ST_ADD_LINK: begin
        if (!op_ok) begin
          emit = 1'b1;
        end else if (queued[op_slot]) begin
          emit       = 1'b1;
          emit_error = 1'b1;
        end else begin
          next_we              = wqm_pkg::link_ok(tail);
          next_waddr           = tail[wqm_pkg::SLOT_W-1:0];
          next_wdata           = wqm_pkg::LINK_W'(op_id);
          prev_we              = 1'b1;
          prev_wdata           = tail;
          ntf_we               = 1'b1;
          queued_next[op_slot] = 1'b1;
          if (!wqm_pkg::link_ok(tail)) begin
            head_next = wqm_pkg::LINK_W'(op_id);
          end
          tail_next = wqm_pkg::LINK_W'(op_id);
        end
      end
      wqm_pkg::ST_ADD_TERM: begin
        next_we = 1'b1;
        emit    = 1'b1;
      end
      wqm_pkg::ST_DELETE: begin
        emit = 1'b1;
        if (op_ok && queued[op_slot]) begin
          if (wqm_pkg::link_ok(prev_rd)) begin
            next_we    = 1'b1;
            next_waddr = prev_rd[wqm_pkg::SLOT_W-1:0];
            next_wdata = wqm_pkg::link_norm(next_rd);
          end else begin
            head_next = wqm_pkg::link_norm(next_rd);
          end
          if (wqm_pkg::link_ok(next_rd)) begin
            prev_we    = 1'b1;
            prev_waddr = next_rd[wqm_pkg::SLOT_W-1:0];
            prev_wdata = wqm_pkg::link_norm(prev_rd);
          end else begin
            tail_next = wqm_pkg::link_norm(prev_rd);
          end
          queued_next[op_slot] = 1'b0;
        end
      end
      wqm_pkg::ST_WAKE_ONE: begin
        emit = 1'b1;
        if (wqm_pkg::link_ok(head)) begin
          if (wqm_pkg::link_ok(next_rd)) begin
            head_next  = next_rd;
            prev_we    = 1'b1;
            prev_waddr = next_rd[wqm_pkg::SLOT_W-1:0];
          end else begin
            head_next = wqm_pkg::NULL_SLOT;
            tail_next = wqm_pkg::NULL_SLOT;
          end
          queued_next[head[wqm_pkg::SLOT_W-1:0]] = 1'b0;
          emit_valid  = 1'b1;
          emit_id     = wqm_pkg::ID_W'(head[wqm_pkg::SLOT_W-1:0]);
          emit_notify = ntf_rd;
        end
      end
      wqm_pkg::ST_WAKE_ALL: begin
        emit = 1'b1;
        if (wqm_pkg::link_ok(cur)) begin
          queued_next[cur[wqm_pkg::SLOT_W-1:0]] = 1'b0;
          emit_valid  = 1'b1;
          emit_id     = wqm_pkg::ID_W'(cur[wqm_pkg::SLOT_W-1:0]);
          emit_notify = ntf_rd;
          emit_last   = !wa_more;
          // fetch the successor while this waiter is reported
          cur_next    = next_rd;
          rd_addr     = next_rd[wqm_pkg::SLOT_W-1:0];
          count_next  = count + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= wqm_pkg::ST_IDLE;
      head          <= wqm_pkg::NULL_SLOT;
      tail          <= wqm_pkg::NULL_SLOT;
      queued        <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      head          <= head_next;
      tail          <= tail_next;
      queued        <= queued_next;
      result_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (state == wqm_pkg::ST_IDLE && start) begin
      op_kind   <= in_kind;
      op_id     <= waiter_id;
      op_notify <= notify;
    end
    cur          <= cur_next;
    count        <= count_next;
    woken_valid  <= emit_valid;
    woken_id     <= emit_id;
    woken_notify <= emit_notify;
    last         <= emit_last;
    queue_empty  <= !wqm_pkg::link_ok(head_next);
    error        <= emit_error && (op_kind == wqm_pkg::KIND_ADD);
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    wqm_pkg::kind_t op;
    wqm_pkg::id_t   slot;
    logic           ntf;
    bit             drain;   // hold this item until every pending result is out
  } request_t;

  typedef struct packed {
    logic         vld;
    wqm_pkg::id_t id;
    logic         ntf;
    logic         last;
    logic         empty;
    logic         err;
  } wake_result_t;

  localparam int TOTAL_ITEMS  = 460;
  localparam int CALM_TAIL    = 60;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic [1:0] kind;
  wqm_pkg::id_t waiter_id;
  logic notify;
  logic busy;
  logic result_strobe;
  logic woken_valid;
  wqm_pkg::id_t woken_id;
  logic woken_notify;
  logic last;
  logic queue_empty;
  logic error;

  wait_queue_manager dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .kind(kind),
    .waiter_id(waiter_id),
    .notify(notify),
    .busy(busy),
    .result_strobe(result_strobe),
    .woken_valid(woken_valid),
    .woken_id(woken_id),
    .woken_notify(woken_notify),
    .last(last),
    .queue_empty(queue_empty),
    .error(error)
  );

  always #1 clk = ~clk;

  request_t     request_q[$];
  wake_result_t wakeup_q[$];
  int           lineup[$];     // stimulus-side view of queue order, steers ids
  int           total_requests;
  int           accepted_cnt = 0;
  int           fail_count = 0;
  logic         taken;
  int           gap_left;

  // wait queue image
  wqm_pkg::link_t succ_tbl[wqm_pkg::NUM_WAITERS];
  wqm_pkg::link_t pred_tbl[wqm_pkg::NUM_WAITERS];
  bit             waiting[wqm_pkg::NUM_WAITERS];
  bit             wants_signal[wqm_pkg::NUM_WAITERS];
  wqm_pkg::link_t head_ptr;
  wqm_pkg::link_t tail_ptr;

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [4:0] got, logic [4:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic push_wakeup(logic vld, wqm_pkg::link_t id, logic ntf, logic lst,
                             logic err);
    wake_result_t r;
    r.vld   = vld;
    r.id    = id[wqm_pkg::ID_W-1:0];
    r.ntf   = ntf;
    r.last  = lst;
    r.empty = !(head_ptr < wqm_pkg::NULL_SLOT);
    r.err   = err;
    wakeup_q.push_back(r);
  endtask

  task automatic wait_queue_step(wqm_pkg::kind_t op, wqm_pkg::id_t id, logic ntf);
    wqm_pkg::link_t p;
    wqm_pkg::link_t n;
    wqm_pkg::link_t cur;
    int cnt;
    case (op)
      wqm_pkg::KIND_ADD: begin
        if (waiting[id]) begin
          push_wakeup(1'b0, '0, 1'b0, 1'b1, 1'b1);
        end else begin
          waiting[id] = 1'b1;
          wants_signal[id] = ntf;
          succ_tbl[id] = wqm_pkg::NULL_SLOT;
          pred_tbl[id] = tail_ptr;
          if (tail_ptr < wqm_pkg::NULL_SLOT) succ_tbl[tail_ptr] = wqm_pkg::link_t'(id);
          else head_ptr = wqm_pkg::link_t'(id);
          tail_ptr = wqm_pkg::link_t'(id);
          push_wakeup(1'b0, '0, 1'b0, 1'b1, 1'b0);
        end
      end
      wqm_pkg::KIND_DELETE: begin
        if (waiting[id]) begin
          p = pred_tbl[id];
          n = succ_tbl[id];
          if (n >= wqm_pkg::NULL_SLOT) n = wqm_pkg::NULL_SLOT;
          if (p >= wqm_pkg::NULL_SLOT) p = wqm_pkg::NULL_SLOT;
          if (p < wqm_pkg::NULL_SLOT) succ_tbl[p] = n;
          else head_ptr = n;
          if (n < wqm_pkg::NULL_SLOT) pred_tbl[n] = p;
          else tail_ptr = p;
          waiting[id] = 1'b0;
        end
        push_wakeup(1'b0, '0, 1'b0, 1'b1, 1'b0);
      end
      wqm_pkg::KIND_WAKE_ONE: begin
        cur = head_ptr;
        if (!(cur < wqm_pkg::NULL_SLOT)) begin
          push_wakeup(1'b0, '0, 1'b0, 1'b1, 1'b0);
        end else begin
          n = succ_tbl[cur];
          if (n < wqm_pkg::NULL_SLOT) begin
            head_ptr = n;
            pred_tbl[n] = wqm_pkg::NULL_SLOT;
          end else begin
            head_ptr = wqm_pkg::NULL_SLOT;
            tail_ptr = wqm_pkg::NULL_SLOT;
          end
          waiting[cur] = 1'b0;
          push_wakeup(1'b1, cur, wants_signal[cur], 1'b1, 1'b0);
        end
      end
      default: begin
        cur = head_ptr;
        cnt = 0;
        head_ptr = wqm_pkg::NULL_SLOT;
        tail_ptr = wqm_pkg::NULL_SLOT;
        if (!(cur < wqm_pkg::NULL_SLOT)) begin
          push_wakeup(1'b0, '0, 1'b0, 1'b1, 1'b0);
        end else begin
          while (cur < wqm_pkg::NULL_SLOT && cnt < wqm_pkg::NUM_WAITERS) begin
            n = succ_tbl[cur];
            waiting[cur] = 1'b0;
            push_wakeup(1'b1, cur, wants_signal[cur],
                        !(n < wqm_pkg::NULL_SLOT && cnt + 1 < wqm_pkg::NUM_WAITERS),
                        1'b0);
            cnt++;
            cur = n;
          end
        end
      end
    endcase
  endtask

  function automatic int lineup_pos(int id);
    foreach (lineup[i]) if (lineup[i] == id) return i;
    return -1;
  endfunction

  task automatic queue_item(wqm_pkg::kind_t op, int id, bit ntf, bit drain);
    request_t r;
    int pos;
    r.op = op;
    r.slot = wqm_pkg::id_t'(id);
    r.ntf = ntf;
    r.drain = drain;
    request_q.push_back(r);
    pos = lineup_pos(id);
    case (op)
      wqm_pkg::KIND_ADD:      if (pos < 0) lineup.push_back(id);
      wqm_pkg::KIND_DELETE:   if (pos >= 0) lineup.delete(pos);
      wqm_pkg::KIND_WAKE_ONE: if (lineup.size() != 0) void'(lineup.pop_front());
      default:                lineup.delete();
    endcase
  endtask

  task automatic queue_fill_burst(bit drain);
    int ids[$];
    int j;
    int tmp;
    for (int i = 0; i < wqm_pkg::NUM_WAITERS; i++)
      if (lineup_pos(i) < 0) ids.push_back(i);
    for (int i = ids.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = ids[i];
      ids[i] = ids[j];
      ids[j] = tmp;
    end
    foreach (ids[i])
      queue_item(wqm_pkg::KIND_ADD, ids[i], $urandom_range(0, 1), drain && i == 0);
    if ($urandom_range(0, 1))
      repeat ($urandom_range(1, 3))
        queue_item(wqm_pkg::KIND_DELETE, lineup[$urandom_range(0, lineup.size() - 1)],
                   0, 0);
    queue_item(wqm_pkg::KIND_WAKE_ALL, $urandom_range(0, 31), $urandom_range(0, 1), 0);
  endtask

  // driver
  always @(negedge clk) begin
    request_t r;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // item still waiting for the block
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (request_q.size() == 0) begin
      start <= 1'b0;
    end else if (request_q[0].drain && wakeup_q.size() != 0) begin
      start <= 1'b0;
    end else begin
      r = request_q.pop_front();
      kind <= r.op;
      waiter_id <= r.slot;
      notify <= r.ntf;
      start <= 1'b1;
      // idle stretches alternate with busy stretches; none near the end
      if (request_q.size() > CALM_TAIL && (request_q.size() / 50) % 3 != 0
          && $urandom_range(0, 3) == 0)
        gap_left <= $urandom_range(1, 11);
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    wake_result_t want;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (result_strobe) begin
        if (wakeup_q.size() == 0) begin
          flag_mismatch("result with nothing expected");
        end else begin
          want = wakeup_q.pop_front();
          check_field("woken_valid", 5'(woken_valid), 5'(want.vld));
          check_field("woken_id", woken_id, want.id);
          check_field("woken_notify", 5'(woken_notify), 5'(want.ntf));
          check_field("last", 5'(last), 5'(want.last));
          check_field("queue_empty", 5'(queue_empty), 5'(want.empty));
          check_field("error", 5'(error), 5'(want.err));
        end
      end
      if (start && !busy) begin
        wait_queue_step(wqm_pkg::kind_t'(kind), waiter_id, notify);
        accepted_cnt++;
      end
    end
  end

  initial begin
    int roll;
    int id;
    rst = 1'b1;
    start = 1'b0;
    kind = wqm_pkg::KIND_ADD;
    waiter_id = '0;
    notify = 1'b0;
    gap_left = 0;
    head_ptr = wqm_pkg::NULL_SLOT;
    tail_ptr = wqm_pkg::NULL_SLOT;
    foreach (waiting[i]) waiting[i] = 1'b0;

    // directed part
    queue_item(wqm_pkg::KIND_WAKE_ONE, 0, 0, 0);    // empty queue
    queue_item(wqm_pkg::KIND_WAKE_ALL, 31, 1, 0);   // empty queue
    queue_item(wqm_pkg::KIND_DELETE, 7, 0, 0);      // not queued
    queue_item(wqm_pkg::KIND_ADD, 0, 1, 0);
    queue_item(wqm_pkg::KIND_ADD, 31, 0, 0);
    queue_item(wqm_pkg::KIND_ADD, 0, 0, 0);         // duplicate
    queue_item(wqm_pkg::KIND_ADD, 16, 1, 0);
    queue_item(wqm_pkg::KIND_DELETE, 31, 0, 0);     // middle
    queue_item(wqm_pkg::KIND_WAKE_ONE, 31, 1, 0);
    queue_item(wqm_pkg::KIND_ADD, 21, 1, 0);
    queue_item(wqm_pkg::KIND_DELETE, 16, 1, 0);     // head
    queue_item(wqm_pkg::KIND_DELETE, 21, 0, 0);     // only entry
    queue_item(wqm_pkg::KIND_DELETE, 21, 0, 0);
    queue_item(wqm_pkg::KIND_ADD, 10, 0, 0);
    queue_item(wqm_pkg::KIND_ADD, 11, 1, 0);
    queue_item(wqm_pkg::KIND_ADD, 12, 0, 0);
    queue_item(wqm_pkg::KIND_DELETE, 12, 0, 0);     // tail
    queue_item(wqm_pkg::KIND_WAKE_ALL, 0, 0, 0);
    queue_item(wqm_pkg::KIND_ADD, 31, 1, 0);
    queue_item(wqm_pkg::KIND_WAKE_ALL, 5, 1, 0);    // single waiter
    queue_item(wqm_pkg::KIND_ADD, 5, 1, 0);
    queue_item(wqm_pkg::KIND_WAKE_ONE, 0, 0, 0);

    // random part: full-queue bursts plus a mix that keeps the list deep
    queue_fill_burst(1'b1);
    while (request_q.size() < TOTAL_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 4 && lineup.size() < 8) begin
        queue_fill_burst($urandom_range(0, 1));
      end else if (roll < 46) begin
        id = $urandom_range(0, 31);
        if (lineup.size() < wqm_pkg::NUM_WAITERS && $urandom_range(0, 6) != 0)
          while (lineup_pos(id) >= 0) id = $urandom_range(0, 31);
        queue_item(wqm_pkg::KIND_ADD, id, $urandom_range(0, 1), 0);
      end else if (roll < 70) begin
        id = $urandom_range(0, 31);
        if (lineup.size() != 0 && $urandom_range(0, 3) != 0)
          id = lineup[$urandom_range(0, lineup.size() - 1)];
        queue_item(wqm_pkg::KIND_DELETE, id, $urandom_range(0, 1), 0);
      end else if (roll < 88) begin
        queue_item(wqm_pkg::KIND_WAKE_ONE, $urandom_range(0, 31), $urandom_range(0, 1),
                   $urandom_range(0, 40) == 0);
      end else if (roll < 92) begin
        queue_item(wqm_pkg::KIND_WAKE_ALL, $urandom_range(0, 31), $urandom_range(0, 1),
                   0);
      end else begin
        queue_item(wqm_pkg::kind_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                   $urandom_range(0, 1), 0);
      end
    end
    total_requests = request_q.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_cnt < total_requests || wakeup_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
